FILE: hdl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 stream hasher, its checker and its bench.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned ROUNDS       = 80;
    localparam logic [2:0]  LAST_WORD    = 3'(DIGEST_WORDS - 1);

    localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_END = 32'hCA62C1D6;

    localparam logic [7:0]  PAD_MARK = 8'h80;

    // Round phases: the boundary rounds where f and K change
    localparam logic [6:0]  PHASE_PAR = 7'd20;
    localparam logic [6:0]  PHASE_MAJ = 7'd40;
    localparam logic [6:0]  PHASE_END = 7'd60;
    localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);

    // Block positions
    localparam logic [5:0]  LEN_POS   = 6'd56;
    localparam logic [5:0]  BLOCK_END = 6'd63;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

FILE: hdl/sha1_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Streaming SHA-1 over a byte stream, five digest beats per message.
//
// Each message byte is shifted into a 512-bit block line. When a 64-byte
// block is complete the input stalls for the 80 rounds through the single
// shared round adder and then the hash update. On the last beat the block
// pads itself one byte per cycle, pausing while a full block is compressed
// (0x80, zeros, then the 64-bit bit length; up to 72 bytes), runs one or two
// further compressions and presents the digest as five output beats, word 0
// first, before it takes the next message. The message schedule is kept as a
// 16-word rolling line inside the same block line.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        msg_last,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        digest_last
);
    import sha1_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] hash_reg [DIGEST_WORDS];
    logic [31:0] hash_next [DIGEST_WORDS];
    logic [63:0] byte_count_reg, byte_count_next;
    logic [5:0]  blk_pos_reg, blk_pos_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  word_idx_reg, word_idx_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        len_mode_reg, len_mode_next;
    logic        fin_reg, fin_next;

    // payload
    logic [511:0] sched_reg, sched_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [63:0]  len_sh_reg, len_sh_next;

    logic        in_beat, out_beat;
    logic        shift_en;
    logic [7:0]  shift_byte;
    logic        in_len;
    logic [63:0] len_src;
    logic [7:0]  pad_byte;
    logic [31:0] w0, w2, w8, w13, w_new;
    logic [31:0] f_val, k_val, tmp;

    assign byte_stall   = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);
    assign in_beat      = byte_valid && !byte_stall;
    assign out_beat     = digest_valid && !digest_stall;

    assign digest_word  = hash_reg[word_idx_reg];
    assign word_number  = word_idx_reg;
    assign digest_last  = (word_idx_reg == LAST_WORD);

    // Padding byte source
    assign in_len   = len_mode_reg || (!first_reg && blk_pos_reg == LEN_POS);
    assign len_src  = len_mode_reg ? len_sh_reg : {byte_count_reg[60:0], 3'b000};
    assign pad_byte = first_reg ? PAD_MARK : (in_len ? len_src[63:56] : 8'h00);

    // Rolling schedule: word i of the line is W[t+i]
    assign w0    = sched_reg[511:480];
    assign w2    = sched_reg[447:416];
    assign w8    = sched_reg[255:224];
    assign w13   = sched_reg[95:64];
    assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                    w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

    always_comb
    begin
        if (round_reg < PHASE_PAR)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_CH;
        end
        else if (round_reg < PHASE_MAJ)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_PAR;
        end
        else if (round_reg < PHASE_END)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_MAJ;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_END;
        end
    end

    assign tmp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w0 + k_val;

    always_comb
    begin
        state_next      = state_reg;
        hash_next       = hash_reg;
        byte_count_next = byte_count_reg;
        blk_pos_next    = blk_pos_reg;
        round_next      = round_reg;
        word_idx_next   = word_idx_reg;
        pad_next        = pad_reg;
        first_next      = first_reg;
        len_mode_next   = len_mode_reg;
        fin_next        = fin_reg;
        len_sh_next     = len_sh_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        e_next          = e_reg;
        shift_en        = 1'b0;
        shift_byte      = msg_byte;
        sched_next      = sched_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (msg_last)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                    if (has_byte)
                    begin
                        shift_en        = 1'b1;
                        byte_count_next = byte_count_reg + 64'd1;
                        blk_pos_next    = blk_pos_reg + 6'd1;
                        if (blk_pos_reg == BLOCK_END)
                        begin
                            state_next = ST_ROUND;
                        end
                    end
                end
            end

            ST_PAD:
            begin
                shift_en     = 1'b1;
                shift_byte   = pad_byte;
                blk_pos_next = blk_pos_reg + 6'd1;
                first_next   = 1'b0;
                if (in_len)
                begin
                    len_mode_next = 1'b1;
                    len_sh_next   = {len_src[55:0], 8'h00};
                end
                if (blk_pos_reg == BLOCK_END)
                begin
                    fin_next   = in_len;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                a_next     = tmp;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                sched_next = {sched_reg[479:0], w_new};
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                hash_next[0] = hash_reg[0] + a_reg;
                hash_next[1] = hash_reg[1] + b_reg;
                hash_next[2] = hash_reg[2] + c_reg;
                hash_next[3] = hash_reg[3] + d_reg;
                hash_next[4] = hash_reg[4] + e_reg;
                if (fin_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT:
            begin
                if (out_beat)
                begin
                    word_idx_next = word_idx_reg + 3'd1;
                    if (word_idx_reg == LAST_WORD)
                    begin
                        word_idx_next   = '0;
                        hash_next       = INIT_HASH;
                        byte_count_next = '0;
                        pad_next        = 1'b0;
                        len_mode_next   = 1'b0;
                        fin_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (shift_en)
        begin
            sched_next = {sched_reg[503:0], shift_byte};
        end

        // working words pick up the chaining value as a compression starts
        if (state_next == ST_ROUND && state_reg != ST_ROUND)
        begin
            a_next = hash_reg[0];
            b_next = hash_reg[1];
            c_next = hash_reg[2];
            d_next = hash_reg[3];
            e_next = hash_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hash_reg       <= INIT_HASH;
            byte_count_reg <= '0;
            blk_pos_reg    <= '0;
            round_reg      <= '0;
            word_idx_reg   <= '0;
            pad_reg        <= 1'b0;
            first_reg      <= 1'b0;
            len_mode_reg   <= 1'b0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hash_reg       <= hash_next;
            byte_count_reg <= byte_count_next;
            blk_pos_reg    <= blk_pos_next;
            round_reg      <= round_next;
            word_idx_reg   <= word_idx_next;
            pad_reg        <= pad_next;
            first_reg      <= first_next;
            len_mode_reg   <= len_mode_next;
            fin_reg        <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg  <= sched_next;
        len_sh_reg <= len_sh_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
    end

endmodule

FILE: hdl/sha1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks on the hasher's digest sequencing and input stall, bound into the hasher.
// ----------------------------------------------------------------------------
module sha1_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_stall,
    input  logic        digest_valid,
    input  logic        digest_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_number,
    input  logic        digest_last
);
    import sha1_pkg::*;

    logic digest_beat;
    assign digest_beat = digest_valid && !digest_stall;

    // a stalled digest beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest_word)
            && $stable(word_number))
        else $error("digest beat changed while stalled");

    // no new input while a digest is on its way out
    a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> byte_stall)
        else $error("input accepted during digest output");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest_last == (word_number == LAST_WORD))
            && (word_number <= LAST_WORD))
        else $error("digest_last or word_number out of step");

    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        digest_beat && !digest_last |=> digest_valid
            && word_number == $past(word_number) + 3'd1)
        else $error("digest words not in order");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        digest_beat && digest_last |=> !digest_valid)
        else $error("digest output continued past last word");

endmodule

bind sha1_stream_hasher sha1_checker u_sha1_checker (.*);

FILE: test/tb_sha1_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_stream_hasher
// Self-checking bench for the streaming SHA-1 hasher.
//
// Messages go in one byte per beat. A model of the hash inside the bench
// computes the five digest words of every message that is closed, and the
// output beats are checked against it in order. A short directed run covers
// empty messages, ignored beats and the byte extremes. Random messages
// follow, with lengths biased towards the padding boundaries, under four
// phases of input idling and output stalling.
// ----------------------------------------------------------------------------
module tb_sha1_stream_hasher;
    import sha1_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  number;
        logic        last;
    } digest_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  msg_byte;
    logic        has_byte;
    logic        msg_last;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_last;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int items_sent     = 0;

    digest_beat_t expected_digest[$];

    // model state: running hash, current block, message length in bytes
    logic [31:0] hash_state [DIGEST_WORDS];
    logic [31:0] block_words [16];
    logic [63:0] msg_bytes;

    sha1_stream_hasher uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .msg_byte     (msg_byte),
        .has_byte     (has_byte),
        .msg_last     (msg_last),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_number  (word_number),
        .digest_last  (digest_last)
    );

    always #2 clk = ~clk;

    function automatic void put_msg_byte(input logic [5:0] pos, input logic [7:0] b);
        block_words[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, x, tmp;
        w = block_words;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int t = 0; t < ROUNDS; t++)
        begin
            if (t >= 16)
            begin
                x = w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16];
                w[t % 16] = {x[30:0], x[31]};
            end
            if (t < PHASE_PAR)
            begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end
            else if (t < PHASE_MAJ)
            begin
                f = b ^ c ^ d;
                k = K_PAR;
            end
            else if (t < PHASE_END)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_END;
            end
            tmp = {a[26:0], a[31:27]} + f + e + w[t % 16] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void sha1_absorb_item(input logic [7:0] b, input logic has,
                                             input logic last);
        logic [5:0]   pos;
        logic [63:0]  bit_len;
        digest_beat_t beat;
        if (has)
        begin
            put_msg_byte(msg_bytes[5:0], b);
            msg_bytes++;
            if (msg_bytes[5:0] == 6'd0)
                compress_block();
        end
        if (last)
        begin
            pos     = msg_bytes[5:0];
            bit_len = msg_bytes << 3;
            put_msg_byte(pos, PAD_MARK);
            for (int p = pos + 1; p < 64; p++)
                put_msg_byte(6'(p), 8'h00);
            // no room left for the length: it spills into a second block
            if (pos >= LEN_POS)
            begin
                compress_block();
                foreach (block_words[i])
                    block_words[i] = '0;
            end
            block_words[14] = bit_len[63:32];
            block_words[15] = bit_len[31:0];
            compress_block();
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                beat.word   = hash_state[i];
                beat.number = 3'(i);
                beat.last   = (3'(i) == LAST_WORD);
                expected_digest.push_back(beat);
            end
            hash_state = INIT_HASH;
            msg_bytes  = '0;
        end
    endfunction

    // digest checker and output stall
    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (expected_digest.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected digest beat word=%h number=%0d last=%b",
                             $realtime, digest_word, word_number, digest_last);
                mismatch_count++;
            end
            else
            begin
                want = expected_digest.pop_front();
                if (digest_word !== want.word || word_number !== want.number ||
                    digest_last !== want.last)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b",
                                 $realtime, want.word, want.number, want.last,
                                 digest_word, word_number, digest_last);
                    mismatch_count++;
                end
            end
        end
        digest_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        msg_byte   <= b;
        has_byte   <= has;
        msg_last   <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sha1_absorb_item(b, has, last);
        if (has || last)
            items_sent++;
    endtask

    // drop valid and hold off until every pending digest beat is out
    task automatic wait_digests_drained();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (expected_digest.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(input int len);
        bit empty_end;
        empty_end = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
        end
        if (empty_end)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic run_random_messages(input int target);
        int pad_boundary_len [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        int start;
        int len;
        int pick;
        start = items_sent;
        while (items_sent - start < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                len = $urandom_range(0, 20);
            else if (pick < 8)
                len = pad_boundary_len[$urandom_range(0, 7)];
            else
                len = $urandom_range(0, 130);
            send_message(len);
            if ($urandom_range(0, 7) == 0)
                wait_digests_drained();
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_beat(8'hA5, 1'b0, 1'b0);   // no byte, no end: ignored
        send_beat(8'h00, 1'b0, 1'b1);   // empty message
        send_beat(8'hFF, 1'b0, 1'b1);   // empty again, after the hash reload
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h3C, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);   // end beat with no byte after data
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        wait_digests_drained();
    endtask

    task automatic test_no_idling();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_message(55);               // length just fits the final block
        send_message(56);               // length forces an extra block
        run_random_messages(10);
        wait_digests_drained();
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 71;
        stall_pct     = 0;
        run_random_messages(35);
        wait_digests_drained();
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        stall_pct     = 71;
        run_random_messages(35);
        wait_digests_drained();
    endtask

    task automatic test_both_idle();
        send_idle_pct = 8;
        stall_pct     = 8;
        run_random_messages(35);
        wait_digests_drained();
    endtask

    initial
    begin
        hash_state = INIT_HASH;
        msg_bytes  = '0;
        foreach (block_words[i])
            block_words[i] = '0;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        msg_byte   <= 8'h00;
        has_byte   <= 1'b0;
        msg_last   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        wait_digests_drained();
        repeat (400) @(posedge clk);
        if (mismatch_count == 0 && expected_digest.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1_600_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
